@@ hw/rtl/best_fit_allocator_coalescing_defines.svh @@
// ----------------------------------------------------------------------------
// Best-fit allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_ALLOCATOR_COALESCING_DEFINES_SVH
`define BEST_FIT_ALLOCATOR_COALESCING_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and held off during reset.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and held off during reset.
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Types, field widths and codes shared by the allocator files.
// ----------------------------------------------------------------------------
package bfa_pkg;

  // Width of one slot field and of the internal placement arithmetic.
  localparam int SW   = 17;
  localparam int CW   = 19;
  localparam int EP_W = 8;

  typedef logic [SW-1:0] val_t;
  typedef logic [CW-1:0] calc_t;

  // One free-slot table entry.
  typedef struct packed {
    val_t start;
    val_t length;
  } slot_t;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_LOOKCHK,
    S_SCAN,
    S_UPD1,
    S_UPD2,
    S_DROP_RD,
    S_DROP_WT,
    S_DROP_WR,
    S_FIN,
    S_DONE,
    S_CLEAR
  } state_e;

endpackage

@@ hw/rtl/bfa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/best_fit_allocator_coalescing.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator with coalescing
// Free-slot table and per-block end store held in synchronous RAMs.
// ----------------------------------------------------------------------------
// An allocate sweeps the free-slot table through its single read port at
// one entry a cycle, with a three-stage fit pipeline behind it, followed by
// read-modify-write steps on the table and the end store; a free does the
// same after reading its block end. Invalid or null frees finish without a
// sweep. A result waits in an output register, so the next request is taken
// while it is still stalled. Writing arena_size restarts the table as one
// free slot in the same cycle; old block ends are retired by an 8-bit epoch
// mark. When the epoch wraps round, which happens on every 256th write, a
// clearing pass over every end-store entry (8192 entries at the default
// size) runs first, and requests are held off until it has finished. After
// reset, an initial state seeds the first table entry.
module best_fit_allocator_coalescing #(
  parameter int ARENA_BYTES  = 65536,
  parameter int MAX_SLOTS    = 64,
  parameter int MIN_ALIGN    = 8,
  parameter int HEADER_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  bfa_pkg::val_t       cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [16:0]         request_bytes_i,
  input  logic [3:0]          align_log2_i,
  input  logic [15:0]         address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [15:0]         alloc_address_o,
  output logic [16:0]         free_bytes_o
);
  import bfa_pkg::*;

  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int MA_LG     = $clog2(MIN_ALIGN);
  localparam int END_DEPTH = ARENA_BYTES / MIN_ALIGN;
  localparam int ADR_SPAN  = 65536 / MIN_ALIGN;
  localparam int MEM_DEPTH = (END_DEPTH < ADR_SPAN) ? END_DEPTH : ADR_SPAN;
  localparam int EA_W      = $clog2(MEM_DEPTH);
  localparam int END_W     = EP_W + SW;
  localparam int RST_ARENA = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;

  state_e state_q, state_d;

  // Request registers.
  logic              kind_q;
  val_t              size_q;
  calc_t             amask_q;
  val_t              hdr_q;
  val_t              end_q;
  logic [EA_W-1:0]   ea_q;

  // Allocator state held in flip-flops.
  logic [CNT_W-1:0]  count_q;
  val_t              free_q;
  val_t              arena_q;
  logic [EP_W-1:0]   epoch_q;
  logic [EA_W-1:0]   clr_q;

  // Scan pipeline.
  logic              issuing_q, v1_q, v2_q;
  logic [IDX_W-1:0]  iss_q, idx1_q, idx2_q;
  val_t              s2_q, l2_q;
  calc_t             p2_q, sl2_q;

  // Best fit and neighbour results.
  logic              found_q;
  logic [IDX_W-1:0]  b_idx_q;
  val_t              b_s_q, b_l_q;
  calc_t             b_p_q, b_e_q;
  logic              hp_q, hn_q;
  logic [IDX_W-1:0]  pi_q, ni_q, drop_q;
  val_t              ps_q, ns_q, nl_q;

  // Pending and delivered result.
  logic [1:0]        st_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [15:0]       out_addr_q;
  val_t              out_free_q;

  // RAM ports.
  logic              sl_we;
  logic [IDX_W-1:0]  sl_waddr, sl_raddr;
  slot_t             sl_wdata, sl_rdata;
  logic              en_we;
  logic [EA_W-1:0]   en_waddr;
  logic [END_W-1:0]  en_wdata, en_rdata;

  // Combinational helpers.
  val_t              cfg_arena;
  calc_t             b_hdr, stage_e, free_sum, used;
  logic              gap, exact, full, fit, better, scan_done, accept;
  logic [IDX_W-1:0]  last_idx;
  logic [3:0]        lg_eff;
  val_t              look_end;
  logic [15:0]       free_idx;
  calc_t             b_pidx;

  bfa_ram #(.WIDTH(2 * SW), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (sl_we),
    .waddr_i(sl_waddr),
    .wdata_i(sl_wdata),
    .raddr_i(sl_raddr),
    .rdata_o(sl_rdata)
  );

  bfa_ram #(.WIDTH(END_W), .DEPTH(MEM_DEPTH)) u_end_ram (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(en_waddr),
    .wdata_i(en_wdata),
    .raddr_i(ea_q),
    .rdata_o(en_rdata)
  );

  // Clamp the written arena size to the supported range.
  always_comb begin
    if (cfg_wdata_i < val_t'(64)) begin
      cfg_arena = val_t'(64);
    end else if (32'(cfg_wdata_i) > ARENA_BYTES) begin
      cfg_arena = val_t'(ARENA_BYTES);
    end else begin
      cfg_arena = cfg_wdata_i;
    end
  end

  // Placement of the chosen slot.
  assign b_hdr    = b_p_q - calc_t'(HEADER_BYTES);
  assign gap      = b_hdr > calc_t'(b_s_q);
  assign exact    = b_e_q == (calc_t'(b_s_q) + calc_t'(b_l_q));
  assign full     = count_q >= CNT_W'(MAX_SLOTS);
  assign last_idx = IDX_W'(count_q - CNT_W'(1));
  assign used     = b_e_q - b_hdr;
  assign free_sum = calc_t'(free_q) + calc_t'(end_q) - calc_t'(hdr_q);
  assign b_pidx   = b_p_q >> MA_LG;

  // Fit test of the entry in the last pipeline stage.
  assign stage_e = (p2_q + calc_t'(size_q) + calc_t'(MIN_ALIGN - 1)) &
                   ~calc_t'(MIN_ALIGN - 1);
  assign fit     = stage_e <= sl2_q;
  assign better  = !found_q || (l2_q < b_l_q) || ((l2_q == b_l_q) && (s2_q < b_s_q));

  assign scan_done = !issuing_q && !v1_q && !v2_q;
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign lg_eff    = (align_log2_i < 4'(MA_LG)) ? 4'(MA_LG) : align_log2_i;
  assign free_idx  = address_i >> MA_LG;
  assign look_end  = (en_rdata[END_W-1:SW] == epoch_q) ? en_rdata[SW-1:0] : '0;

  // Slot table write and read port selection.
  always_comb begin
    sl_we    = 1'b0;
    sl_waddr = '0;
    sl_wdata = '0;
    sl_raddr = iss_q;
    if (state_q == S_DROP_RD) begin
      sl_raddr = last_idx;
    end
    if (cfg_we_i) begin
      sl_we    = 1'b1;
      sl_wdata = '{start: '0, length: cfg_arena};
    end else begin
      case (state_q)
        S_INIT: begin
          sl_we    = 1'b1;
          sl_wdata = '{start: '0, length: arena_q};
        end
        S_UPD1: begin
          if (kind_q == KIND_ALLOC) begin
            if (exact && gap) begin
              sl_we    = 1'b1;
              sl_waddr = b_idx_q;
              sl_wdata = '{start: b_s_q, length: SW'(b_hdr - calc_t'(b_s_q))};
            end else if (!exact && gap) begin
              sl_we    = !full;
              sl_waddr = IDX_W'(count_q);
              sl_wdata = '{start: b_s_q, length: SW'(b_hdr - calc_t'(b_s_q))};
            end else if (!exact) begin
              sl_we    = 1'b1;
              sl_waddr = b_idx_q;
              sl_wdata = '{start: SW'(b_e_q),
                           length: SW'(calc_t'(b_s_q) + calc_t'(b_l_q) - b_e_q)};
            end
          end else begin
            if (hp_q && hn_q) begin
              sl_we    = 1'b1;
              sl_waddr = pi_q;
              sl_wdata = '{start: ps_q, length: ns_q + nl_q - ps_q};
            end else if (hp_q) begin
              sl_we    = 1'b1;
              sl_waddr = pi_q;
              sl_wdata = '{start: ps_q, length: end_q - ps_q};
            end else if (hn_q) begin
              sl_we    = 1'b1;
              sl_waddr = ni_q;
              sl_wdata = '{start: hdr_q, length: nl_q + ns_q - hdr_q};
            end else begin
              sl_we    = !full;
              sl_waddr = IDX_W'(count_q);
              sl_wdata = '{start: hdr_q, length: end_q - hdr_q};
            end
          end
        end
        S_UPD2: begin
          sl_we    = 1'b1;
          sl_waddr = b_idx_q;
          sl_wdata = '{start: SW'(b_e_q),
                       length: SW'(calc_t'(b_s_q) + calc_t'(b_l_q) - b_e_q)};
        end
        S_DROP_WR: begin
          sl_we    = 1'b1;
          sl_waddr = drop_q;
          sl_wdata = sl_rdata;
        end
        default: begin
          sl_we = 1'b0;
        end
      endcase
    end
  end

  // Block end store write: record on allocate, retire on free, wipe on clear.
  always_comb begin
    en_we    = 1'b0;
    en_waddr = ea_q;
    en_wdata = {epoch_q, val_t'(0)};
    if (state_q == S_FIN) begin
      if (kind_q == KIND_ALLOC) begin
        en_we    = b_pidx < calc_t'(MEM_DEPTH);
        en_waddr = EA_W'(b_pidx);
        en_wdata = {epoch_q, SW'(b_e_q)};
      end else begin
        en_we = 1'b1;
      end
    end else if (state_q == S_CLEAR) begin
      en_we    = 1'b1;
      en_waddr = clr_q;
      en_wdata = '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_ALLOC) begin
            state_d = S_SCAN;
          end else if ((address_i == '0) || (address_i[MA_LG-1:0] != '0) ||
                       (address_i < 16'(HEADER_BYTES)) ||
                       (32'(free_idx) >= MEM_DEPTH)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: state_d = S_LOOKCHK;
      S_LOOKCHK: begin
        if ((look_end <= hdr_q) || (look_end > arena_q)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if ((kind_q == KIND_ALLOC) && !found_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_UPD1;
          end
        end
      end
      S_UPD1: begin
        if (kind_q == KIND_ALLOC) begin
          if (exact && !gap) begin
            state_d = S_DROP_RD;
          end else if (!exact && gap) begin
            state_d = full ? S_DONE : S_UPD2;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          if (hp_q && hn_q) begin
            state_d = S_DROP_RD;
          end else if (!hp_q && !hn_q && full) begin
            state_d = S_DONE;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_UPD2:    state_d = S_FIN;
      S_DROP_RD: state_d = S_DROP_WT;
      S_DROP_WT: state_d = S_DROP_WR;
      S_DROP_WR: state_d = S_FIN;
      S_FIN:     state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_q == EA_W'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // A wrapping epoch would revive stale ends, so wipe the store first.
    if (cfg_we_i && (epoch_q == '1)) begin
      state_d = S_CLEAR;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Address counter of the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q != S_CLEAR) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_q + EA_W'(1);
    end
  end

  // Allocator control state: count, free total, arena size and epoch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
      free_q  <= val_t'(RST_ARENA);
      arena_q <= val_t'(RST_ARENA);
      epoch_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= CNT_W'(1);
      free_q  <= cfg_arena;
      arena_q <= cfg_arena;
      epoch_q <= epoch_q + EP_W'(1);
    end else begin
      if ((state_q == S_UPD1) && (state_d == S_UPD2)) begin
        count_q <= count_q + CNT_W'(1);
      end
      if ((state_q == S_UPD1) && (kind_q == KIND_FREE) && !hp_q && !hn_q && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (state_q == S_DROP_WR) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (state_q == S_FIN) begin
        if (kind_q == KIND_ALLOC) begin
          free_q <= (used >= calc_t'(free_q)) ? '0 : SW'(calc_t'(free_q) - used);
        end else begin
          free_q <= (free_sum > calc_t'(arena_q)) ? arena_q : SW'(free_sum);
        end
      end
    end
  end

  // Scan pipeline valid bits: issue, RAM read, placement stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      iss_q     <= '0;
    end else begin
      v1_q <= issuing_q && (state_q == S_SCAN);
      v2_q <= v1_q;
      if ((state_q != S_SCAN) && (state_d == S_SCAN)) begin
        issuing_q <= count_q != '0;
        iss_q     <= '0;
      end else if (issuing_q && (state_q == S_SCAN)) begin
        if (iss_q == last_idx) begin
          issuing_q <= 1'b0;
        end else begin
          iss_q <= iss_q + IDX_W'(1);
        end
      end
    end
  end

  // Request capture, scan datapath and result payload.
  always_ff @(posedge clk_i) begin
    idx1_q <= iss_q;
    idx2_q <= idx1_q;
    s2_q   <= sl_rdata.start;
    l2_q   <= sl_rdata.length;
    p2_q   <= (calc_t'(sl_rdata.start) + calc_t'(HEADER_BYTES) + amask_q) & ~amask_q;
    sl2_q  <= calc_t'(sl_rdata.start) + calc_t'(sl_rdata.length);

    if (accept) begin
      kind_q  <= kind_i;
      size_q  <= request_bytes_i;
      amask_q <= (calc_t'(1) << lg_eff) - calc_t'(1);
      hdr_q   <= val_t'(address_i) - val_t'(HEADER_BYTES);
      ea_q    <= EA_W'(free_idx);
      found_q <= 1'b0;
      hp_q    <= 1'b0;
      hn_q    <= 1'b0;
      st_q    <= ST_OK;
    end

    if (state_q == S_LOOKCHK) begin
      end_q <= look_end;
    end

    // Best fit for allocate, neighbour search for free.
    if (v2_q && (state_q == S_SCAN)) begin
      if (kind_q == KIND_ALLOC) begin
        if (fit && better) begin
          found_q <= 1'b1;
          b_idx_q <= idx2_q;
          b_s_q   <= s2_q;
          b_l_q   <= l2_q;
          b_p_q   <= p2_q;
          b_e_q   <= stage_e;
        end
      end else begin
        if (!hn_q && (s2_q == end_q)) begin
          hn_q <= 1'b1;
          ni_q <= idx2_q;
          ns_q <= s2_q;
          nl_q <= l2_q;
        end else if (!hp_q && (sl2_q == calc_t'(hdr_q))) begin
          hp_q <= 1'b1;
          pi_q <= idx2_q;
          ps_q <= s2_q;
        end
      end
    end

    if ((state_q == S_SCAN) && scan_done && (kind_q == KIND_ALLOC) && !found_q) begin
      st_q <= ST_NOFIT;
    end
    if ((state_q == S_UPD1) && (state_d == S_DONE)) begin
      st_q <= ST_FULL;
    end
    if (state_q == S_UPD1) begin
      drop_q <= (kind_q == KIND_ALLOC) ? b_idx_q : ni_q;
    end

    if ((state_q == S_DONE) && (state_d == S_IDLE)) begin
      out_status_q <= st_q;
      out_free_q   <= free_q;
      out_addr_q   <= ((kind_q == KIND_ALLOC) && (st_q == ST_OK)) ? b_p_q[15:0] : '0;
    end
  end

  // Output valid: set on a finished request, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && (state_d == S_IDLE)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o      = state_q != S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign alloc_address_o = out_addr_q;
  assign free_bytes_o    = out_free_q;

endmodule

@@ hw/rtl/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator checker
// Port-level assertions on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "best_fit_allocator_coalescing_defines.svh"

module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [15:0] alloc_address_o,
  input logic [16:0] free_bytes_o
);
  import bfa_pkg::*;

  // A stalled result holds until taken.
  `BFA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(alloc_address_o) && $stable(free_bytes_o), "stalled result changed")

  // Only defined status codes are reported.
  `BFA_ASSERT_NOW(a_status_code, out_valid_o, status_o == ST_OK || status_o == ST_NOFIT || status_o == ST_FULL, "undefined status code")

  // A failed request never reports an address.
  `BFA_ASSERT_NOW(a_fail_addr, out_valid_o && status_o != ST_OK, alloc_address_o == 16'd0, "address on failure")

  // Once a request is taken, the input is held off in the following cycle.
  `BFA_ASSERT_NXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

endmodule

bind best_fit_allocator_coalescing bfa_checker u_bfa_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Best-fit allocator testbench
// Sends allocate and free requests, predicts every result with a local
// free-slot table and compares each returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bfa_pkg::*;

  localparam int ARENA_MAX  = 65536;
  localparam int SLOT_LIMIT = 64;
  localparam int GRAIN      = 8;
  localparam int HDR        = 8;
  localparam int END_SLOTS  = ARENA_MAX / GRAIN;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE     = 120;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] address;
    logic [16:0] free_bytes;
  } alloc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  val_t        cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = KIND_ALLOC;
  logic [16:0] request_bytes_i = '0;
  logic [3:0]  align_log2_i = '0;
  logic [15:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [15:0] alloc_address_o;
  logic [16:0] free_bytes_o;

  // Local copy of the allocator state.
  int unsigned arena_bytes;
  int unsigned hole_start [SLOT_LIMIT];
  int unsigned hole_len [SLOT_LIMIT];
  int unsigned hole_count;
  int unsigned bytes_free;
  int unsigned block_limit [END_SLOTS];

  alloc_result_t awaited_results[$];
  int unsigned   live_blocks[$];
  int unsigned   released_blocks[$];
  int            error_count = 0;
  bit            idling_on = 1'b1;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  best_fit_allocator_coalescing i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .request_bytes_i(request_bytes_i),
    .align_log2_i   (align_log2_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .alloc_address_o(alloc_address_o),
    .free_bytes_o   (free_bytes_o)
  );

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Restart the local table as one free slot covering the arena.
  function automatic void restart_table(input int unsigned size);
    arena_bytes = size;
    foreach (block_limit[i]) block_limit[i] = 0;
    foreach (hole_start[i]) begin
      hole_start[i] = 0;
      hole_len[i] = 0;
    end
    hole_len[0] = size;
    hole_count = 1;
    bytes_free = size;
  endfunction

  function automatic void remove_hole(input int unsigned i);
    hole_count--;
    hole_start[i] = hole_start[hole_count];
    hole_len[i] = hole_len[hole_count];
  endfunction

  // Best-fit placement: smallest slot that holds header and rounded end.
  function automatic void predict_allocation(input longint size, input int lg,
                                             output logic [1:0] st,
                                             output longint user_addr);
    longint align, s, l, p, e, b_len, b_s, b_ptr, b_end, b_hdr, used;
    int     best;
    bit     found;
    align = longint'(1) << lg;
    if (align < GRAIN) align = GRAIN;
    found = 0;
    best = 0;
    b_len = 0; b_s = 0; b_ptr = 0; b_end = 0;
    user_addr = 0;
    for (int i = 0; i < hole_count; i++) begin
      s = hole_start[i];
      l = hole_len[i];
      p = (s + HDR + align - 1) & ~(align - 1);
      e = (p + size + GRAIN - 1) & ~longint'(GRAIN - 1);
      if (e <= s + l && (!found || l < b_len || (l == b_len && s < b_s))) begin
        found = 1;
        best = i;
        b_len = l;
        b_s = s;
        b_ptr = p;
        b_end = e;
      end
    end
    if (!found) begin
      st = ST_NOFIT;
      return;
    end
    b_hdr = b_ptr - HDR;
    if (b_end == b_s + b_len) begin
      if (b_hdr > b_s) hole_len[best] = 32'(b_hdr - b_s);
      else remove_hole(best);
    end else begin
      if (b_hdr > b_s) begin
        if (hole_count >= SLOT_LIMIT) begin
          st = ST_FULL;
          return;
        end
        hole_start[hole_count] = 32'(b_s);
        hole_len[hole_count] = 32'(b_hdr - b_s);
        hole_count++;
      end
      hole_start[best] = 32'(b_end);
      hole_len[best] = 32'(b_s + b_len - b_end);
    end
    if (b_ptr / GRAIN < END_SLOTS) block_limit[b_ptr / GRAIN] = 32'(b_end);
    used = b_end - b_hdr;
    bytes_free = (used >= bytes_free) ? 0 : 32'(bytes_free - used);
    user_addr = b_ptr;
    st = ST_OK;
  endfunction

  // Release of [header, end) with merging into the neighbouring slots.
  function automatic logic [1:0] predict_release(input int unsigned addr);
    int unsigned idx, e, hdr, prv, nxt;
    bit          has_prv, has_nxt;
    longint      total;
    has_prv = 0; has_nxt = 0; prv = 0; nxt = 0;
    if (addr == 0 || addr % GRAIN != 0 || addr < HDR) return ST_OK;
    idx = addr / GRAIN;
    e = block_limit[idx];
    hdr = addr - HDR;
    if (e <= hdr || e > arena_bytes) return ST_OK;
    for (int i = 0; i < hole_count; i++) begin
      if (!has_nxt && hole_start[i] == e) begin
        has_nxt = 1;
        nxt = i;
      end else if (!has_prv && hole_start[i] + hole_len[i] == hdr) begin
        has_prv = 1;
        prv = i;
      end
    end
    if (has_prv && has_nxt) begin
      hole_len[prv] = hole_start[nxt] + hole_len[nxt] - hole_start[prv];
      remove_hole(nxt);
    end else if (has_prv) begin
      hole_len[prv] = e - hole_start[prv];
    end else if (has_nxt) begin
      hole_len[nxt] += hole_start[nxt] - hdr;
      hole_start[nxt] = hdr;
    end else begin
      if (hole_count >= SLOT_LIMIT) return ST_FULL;
      hole_start[hole_count] = hdr;
      hole_len[hole_count] = e - hdr;
      hole_count++;
    end
    block_limit[idx] = 0;
    total = longint'(bytes_free) + (e - hdr);
    bytes_free = (total > arena_bytes) ? arena_bytes : 32'(total);
    return ST_OK;
  endfunction

  // Send one request, then predict its result once it is taken.
  task automatic send_request(input logic kind, input int unsigned bytes,
                              input int unsigned lg, input int unsigned addr);
    alloc_result_t r;
    longint        user_addr;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    kind_i = kind;
    request_bytes_i = 17'(bytes);
    align_log2_i = 4'(lg);
    address_i = 16'(addr);
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    user_addr = 0;
    if (kind == KIND_ALLOC) begin
      predict_allocation(longint'(17'(bytes)), int'(4'(lg)), r.status, user_addr);
      if (r.status == ST_OK && user_addr < ARENA_MAX) begin
        live_blocks.push_back(32'(user_addr));
      end
    end else begin
      r.status = predict_release(32'(16'(addr)));
      if (addr % GRAIN == 0 && addr >= HDR && addr < ARENA_MAX &&
          block_limit[addr / GRAIN] == 0) begin
        foreach (live_blocks[i]) begin
          if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            released_blocks.push_back(addr);
            break;
          end
        end
      end
    end
    r.address = user_addr[15:0];
    r.free_bytes = 17'(bytes_free);
    awaited_results.push_back(r);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // Arena size is changed only with nothing in flight.
  task automatic set_arena(input int unsigned size);
    int unsigned clamped;
    wait_drained();
    repeat (SETTLE) @(negedge clk_i);
    cfg_wdata_i = val_t'(size);
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    clamped = size < 64 ? 64 : (size > ARENA_MAX ? ARENA_MAX : size);
    restart_table(clamped);
    foreach (live_blocks[i]) released_blocks.push_back(live_blocks[i]);
    live_blocks.delete();
  endtask

  task automatic free_live(input int unsigned i);
    send_request(KIND_FREE, $urandom, $urandom_range(0, 12), live_blocks[i]);
  endtask

  // Checker: each taken result against the oldest prediction.
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report("results outstanding", 1, 0);
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (alloc_address_o !== want.address)
          report("alloc_address", alloc_address_o, want.address);
        if (free_bytes_o !== want.free_bytes)
          report("free_bytes", free_bytes_o, want.free_bytes);
      end
    end
  end

  // Receiver stalls in random bursts.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Edge sizes and alignments, null and malformed frees, double free.
  task automatic test_directed();
    set_arena(ARENA_MAX);
    send_request(KIND_ALLOC, 0, 0, 0);
    send_request(KIND_ALLOC, 65536, 0, 0);
    send_request(KIND_ALLOC, 1, 12, 0);
    send_request(KIND_ALLOC, 100, 3, 0);
    send_request(KIND_ALLOC, 65535, 15, 0);
    send_request(KIND_ALLOC, 37, 5, 0);
    send_request(KIND_FREE, 0, 0, 0);
    send_request(KIND_FREE, 0, 0, 16'hFFFF);
    send_request(KIND_FREE, 0, 0, 4);
    send_request(KIND_FREE, 0, 0, 3);
    free_live(1);
    free_live(0);
    send_request(KIND_FREE, 0, 0, released_blocks[0]);
    while (live_blocks.size() != 0) free_live(0);
    set_arena(64);
    send_request(KIND_ALLOC, 56, 0, 0);
    send_request(KIND_ALLOC, 0, 0, 0);
    free_live(0);
    send_request(KIND_ALLOC, 17, 4, 0);
    send_request(KIND_ALLOC, 0, 0, 0);
    set_arena(0);
    send_request(KIND_ALLOC, 64, 0, 0);
  endtask

  // Fragment the arena until the slot table overflows on free and allocate.
  task automatic test_table_full();
    int unsigned held[$];
    set_arena(ARENA_MAX);
    repeat (140) send_request(KIND_ALLOC, 8, 0, 0);
    held = live_blocks;
    for (int i = 0; i < held.size(); i += 2) send_request(KIND_FREE, 0, 0, held[i]);
    send_request(KIND_ALLOC, 8, 12, 0);
    send_request(KIND_ALLOC, 100, 9, 0);
    wait_drained();
    for (int i = 1; i < held.size(); i += 2) send_request(KIND_FREE, 0, 0, held[i]);
    while (live_blocks.size() != 0) free_live(0);
  endtask

  // Random mix: mostly allocate and free of live blocks, some noise.
  task automatic test_random(input int unsigned size, input int count);
    int unsigned roll, bytes;
    set_arena(size);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (n == count / 2) wait_drained();
      if (roll < 52 || (roll < 88 && live_blocks.size() == 0)) begin
        case ($urandom_range(0, 9))
          0:       bytes = $urandom_range(0, 65536);
          1, 2:    bytes = $urandom_range(0, arena_bytes / 4);
          default: bytes = $urandom_range(0, 64);
        endcase
        send_request(KIND_ALLOC, bytes, $urandom_range(0, 12), $urandom);
      end else if (roll < 88) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else if (roll < 94 && released_blocks.size() != 0) begin
        send_request(KIND_FREE, $urandom, $urandom_range(0, 12),
                     released_blocks[$urandom_range(0, released_blocks.size() - 1)]);
      end else begin
        send_request(KIND_FREE, $urandom, $urandom_range(0, 12),
                     ($urandom_range(0, 65535) & 16'hFFF8) | $urandom_range(1, 7));
      end
    end
  endtask

  initial begin
    restart_table(ARENA_MAX);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);
    test_directed();
    test_table_full();
    test_random(ARENA_MAX, 180);
    test_random(64, 60);
    test_random($urandom_range(64, 65536), 120);
    wait_drained();
    idling_on = 1'b0;
    test_random(1024, 140);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
